@@ sv/mwpm_pkg.sv @@
// Package for the max-weight perfect matching block: sizes, value types,
// sequencer states and the weight memory write request.
// No dependencies.
`default_nettype none

package mwpm_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int WEIGHT_BITS  = 16;
   localparam int LABEL_BITS   = 24;
   localparam int SLACK_BITS   = LABEL_BITS + 1;
   localparam int VID_BITS     = $clog2(MAX_VERTICES);
   localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
   localparam int EDGE_SLOTS   = MAX_VERTICES * MAX_VERTICES;
   localparam int ADDR_BITS    = 2 * VID_BITS;

   typedef logic [VID_BITS-1:0]           vid_type;
   typedef logic [CNT_BITS-1:0]           cnt_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic signed [WEIGHT_BITS-1:0] weight_type;
   typedef logic signed [LABEL_BITS-1:0]  label_type;
   typedef logic signed [SLACK_BITS-1:0]  slack_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      weight_type data;
   } wr_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROOT,
      ST_CLEAR,
      ST_SLACK,
      ST_BFS_POP,
      ST_BFS,
      ST_DELTA,
      ST_ADJUST,
      ST_SCAN,
      ST_PATH,
      ST_EMIT,
      ST_FAIL
   } state_type;

endpackage

`default_nettype wire

@@ sv/mwpm_if.sv @@
// Channel interfaces of the matching block: request (edge load / start)
// and response (matched pair). Depends on mwpm_pkg.
`default_nettype none

interface mwpm_req_if import mwpm_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       mode;
   vid_type    source_index;
   vid_type    target_index;
   weight_type edge_weight;
   logic       edge_present;

   modport source (output valid, mode, source_index, target_index, edge_weight,
                   edge_present, input ready);
   modport sink   (input valid, mode, source_index, target_index, edge_weight,
                   edge_present, output ready);
endinterface

interface mwpm_rsp_if import mwpm_pkg::*; ();
   logic    valid;
   logic    ready;
   vid_type matched_source;
   vid_type matched_target;
   logic    success;
   logic    last;

   modport source (output valid, matched_source, matched_target, success, last,
                   input ready);
   modport sink   (input valid, matched_source, matched_target, success, last,
                   output ready);
endinterface

`default_nettype wire

@@ sv/mwpm_weight_ram.sv @@
// Edge weight memory: one write port, one registered read port.
// Depends on mwpm_pkg.
`default_nettype none

module mwpm_weight_ram import mwpm_pkg::*; (
   input  logic       clock,
   input  wr_req_type wr_req,
   input  addr_type   rd_addr,
   output weight_type rd_data
);

   weight_type mem [EDGE_SLOTS];
   weight_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/mwpm_engine.sv @@
// Hungarian method sequencer with its shared slack adder and comparator,
// vertex state registers, candidate queue and result register.
// Depends on mwpm_pkg and mwpm_if.
`default_nettype none

module mwpm_engine import mwpm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cnt_type       n_active,
   mwpm_req_if.sink      req,
   mwpm_rsp_if.source    rsp,
   output wr_req_type    ram_wr,
   output addr_type      ram_rd_addr,
   input  weight_type    ram_rd_data
);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      pha_ff, pha_in;
   cnt_type   col_ff, col_in, slk_col_ff, slk_col_in, rnd_ff, rnd_in, qc_ff, qc_in;
   vid_type   cur_src_ff, cur_src_in, slk_src_ff, slk_src_in, qh_ff, qh_in;
   vid_type   path_t_ff, path_t_in;
   logic      path_ok_ff, path_ok_in;
   weight_type best_ff, best_in;
   logic      any_ff, any_in, found_ff, found_in;
   slack_type delta_ff, delta_in;

   logic [EDGE_SLOTS-1:0] ev_ff, ev_in;
   label_type sl_ff [MAX_VERTICES];
   label_type sl_in [MAX_VERTICES];
   label_type tl_ff [MAX_VERTICES];
   label_type tl_in [MAX_VERTICES];
   slack_type ms_ff [MAX_VERTICES];
   slack_type ms_in [MAX_VERTICES];
   vid_type   org_ff [MAX_VERTICES];
   vid_type   org_in [MAX_VERTICES];
   vid_type   pos_ff [MAX_VERTICES];
   vid_type   pos_in [MAX_VERTICES];
   vid_type   pot_ff [MAX_VERTICES];
   vid_type   pot_in [MAX_VERTICES];
   vid_type   ptt_ff [MAX_VERTICES];
   vid_type   ptt_in [MAX_VERTICES];
   vid_type   pts_ff [MAX_VERTICES];
   vid_type   pts_in [MAX_VERTICES];
   vid_type   q_ff [MAX_VERTICES];
   vid_type   q_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] org_ok_ff, org_ok_in, pos_ok_ff, pos_ok_in;
   logic [MAX_VERTICES-1:0] pot_ok_ff, pot_ok_in, ptt_ok_ff, ptt_ok_in;
   logic [MAX_VERTICES-1:0] pts_ok_ff, pts_ok_in, its_ff, its_in, itt_ff, itt_in;

   logic    rsp_valid_ff, rsp_valid_in, rsp_succ_ff, rsp_succ_in;
   logic    rsp_last_ff, rsp_last_in;
   vid_type rsp_src_ff, rsp_src_in, rsp_tgt_ff, rsp_tgt_in;

   // shared decode
   vid_type   rd_s, rd_t, t, m;
   logic      edge_ok, col_lt, slk_lt, cur_lt, bfs_hit, sc_skip, out_free;
   logic      accept, path_done;
   cnt_type   n_last;
   slack_type slack_v;

   // grow request, applied after the state case
   logic    grow_en;
   vid_type g_s, g_t, g_m;

   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign n_last   = n_active - cnt_type'(1);
   assign t        = col_ff[VID_BITS-1:0];
   assign m        = pot_ff[t];
   assign rd_s     = (state_ff == ST_SLACK) ? slk_src_ff : cur_src_ff;
   assign rd_t     = (state_ff == ST_SLACK) ? slk_col_ff[VID_BITS-1:0] : t;
   assign ram_rd_addr = {rd_s, rd_t};
   assign edge_ok  = ev_ff[{rd_s, rd_t}];
   assign col_lt   = col_ff < n_active;
   assign slk_lt   = slk_col_ff < n_active;
   assign cur_lt   = {1'b0, cur_src_ff} < n_active;
   assign slack_v  = SLACK_BITS'(sl_ff[rd_s]) + SLACK_BITS'(tl_ff[rd_t])
                     - SLACK_BITS'(ram_rd_data);
   assign bfs_hit  = edge_ok && !itt_ff[t] && (slack_v == '0);
   assign sc_skip  = itt_ff[t] || !org_ok_ff[t] || (ms_ff[t] != '0);
   assign path_done = !(col_lt && path_ok_ff) || !ptt_ok_ff[path_t_ff];

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.matched_source = rsp_src_ff;
   assign rsp.matched_target = rsp_tgt_ff;
   assign rsp.success        = rsp_succ_ff;
   assign rsp.last           = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req.mode) state_in = ST_INIT;
         end
         ST_INIT: begin
            if (!pha_ff && !(cur_lt && col_lt) && (cur_src_ff == vid_type'(MAX_VERTICES - 1)))
               state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!col_lt) state_in = ST_FAIL;
            else if (!pos_ok_ff[t]) state_in = ST_CLEAR;
         end
         ST_CLEAR: state_in = ST_SLACK;
         ST_SLACK: begin
            if (!pha_ff && !slk_lt) state_in = ret_ff;
         end
         ST_BFS_POP: state_in = (qc_ff != '0) ? ST_BFS : ST_DELTA;
         ST_BFS: begin
            if (!pha_ff && !col_lt) state_in = ST_BFS_POP;
            else if (pha_ff && bfs_hit) state_in = pot_ok_ff[t] ? ST_SLACK : ST_PATH;
         end
         ST_DELTA: begin
            if (!col_lt)
               state_in = (!found_ff || delta_ff == '0) ? ST_FAIL : ST_ADJUST;
         end
         ST_ADJUST: begin
            if (!col_lt) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!col_lt) state_in = ST_BFS_POP;
            else if (!sc_skip) begin
               if (!pot_ok_ff[t]) state_in = ST_PATH;
               else if (!its_ff[m]) state_in = ST_SLACK;
            end
         end
         ST_PATH: begin
            if (path_done) state_in = (rnd_ff == n_last) ? ST_EMIT : ST_ROOT;
         end
         ST_EMIT: begin
            if (out_free && col_ff == n_last) state_in = ST_IDLE;
         end
         ST_FAIL: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ret_in = ret_ff;  pha_in = pha_ff;  col_in = col_ff;
      slk_col_in = slk_col_ff;  rnd_in = rnd_ff;  qc_in = qc_ff;
      cur_src_in = cur_src_ff;  slk_src_in = slk_src_ff;  qh_in = qh_ff;
      path_t_in = path_t_ff;  path_ok_in = path_ok_ff;
      best_in = best_ff;  any_in = any_ff;  found_in = found_ff;  delta_in = delta_ff;
      ev_in = ev_ff;  sl_in = sl_ff;  tl_in = tl_ff;  ms_in = ms_ff;
      org_in = org_ff;  pos_in = pos_ff;  pot_in = pot_ff;  ptt_in = ptt_ff;
      pts_in = pts_ff;  q_in = q_ff;
      org_ok_in = org_ok_ff;  pos_ok_in = pos_ok_ff;  pot_ok_in = pot_ok_ff;
      ptt_ok_in = ptt_ok_ff;  pts_ok_in = pts_ok_ff;  its_in = its_ff;  itt_in = itt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_src_in = rsp_src_ff;  rsp_tgt_in = rsp_tgt_ff;
      rsp_succ_in = rsp_succ_ff;  rsp_last_in = rsp_last_ff;
      ram_wr = '0;
      grow_en = 1'b0;  g_s = '0;  g_t = '0;  g_m = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && !req.mode) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = {req.source_index, req.target_index};
               ram_wr.data = req.edge_weight;
               ev_in[{req.source_index, req.target_index}] = req.edge_present;
            end else if (accept) begin
               cur_src_in = '0;  col_in = '0;  pha_in = 1'b0;
               any_in = 1'b0;  best_in = '0;  rnd_in = '0;
               pos_ok_in = '0;  pot_ok_in = '0;
               for (int i = 0; i < MAX_VERTICES; i++) tl_in[i] = '0;
            end
         end
         ST_INIT: begin
            if (pha_ff) begin
               if (edge_ok && (!any_ff || ram_rd_data > best_ff)) best_in = ram_rd_data;
               if (edge_ok) any_in = 1'b1;
               col_in = col_ff + cnt_type'(1);
               pha_in = 1'b0;
            end else if (cur_lt && col_lt) begin
               pha_in = 1'b1;
            end else begin
               sl_in[cur_src_ff] = any_ff ? LABEL_BITS'(best_ff) : '0;
               cur_src_in = cur_src_ff + vid_type'(1);
               col_in = '0;  any_in = 1'b0;  best_in = '0;
            end
         end
         ST_ROOT: begin
            if (col_lt) begin
               if (!pos_ok_ff[t]) cur_src_in = t;
               else col_in = col_ff + cnt_type'(1);
            end
         end
         ST_CLEAR: begin
            its_in = '0;  itt_in = '0;  pts_ok_in = '0;  ptt_ok_in = '0;  org_ok_in = '0;
            for (int i = 0; i < MAX_VERTICES; i++) ms_in[i] = '0;
            its_in[cur_src_ff] = 1'b1;
            q_in[0] = cur_src_ff;  qh_in = '0;  qc_in = cnt_type'(1);
            slk_src_in = cur_src_ff;  slk_col_in = '0;  pha_in = 1'b0;
            ret_in = ST_BFS_POP;
         end
         ST_SLACK: begin
            if (pha_ff) begin
               if (edge_ok && (!org_ok_ff[rd_t] || slack_v < ms_ff[rd_t])) begin
                  ms_in[rd_t] = slack_v;
                  org_in[rd_t] = slk_src_ff;
                  org_ok_in[rd_t] = 1'b1;
               end
               slk_col_in = slk_col_ff + cnt_type'(1);
               pha_in = 1'b0;
            end else if (slk_lt) begin
               pha_in = 1'b1;
            end
         end
         ST_BFS_POP: begin
            col_in = '0;  pha_in = 1'b0;  found_in = 1'b0;
            if (qc_ff != '0) begin
               cur_src_in = q_ff[qh_ff];
               qh_in = qh_ff + vid_type'(1);
               qc_in = qc_ff - cnt_type'(1);
            end
         end
         ST_BFS: begin
            if (pha_ff) begin
               pha_in = 1'b0;
               col_in = col_ff + cnt_type'(1);
               if (bfs_hit) begin
                  if (!pot_ok_ff[t]) begin
                     ptt_in[t] = cur_src_ff;  ptt_ok_in[t] = 1'b1;
                     path_t_in = t;  path_ok_in = 1'b1;  col_in = '0;
                  end else begin
                     grow_en = 1'b1;  g_s = cur_src_ff;  g_t = t;  g_m = m;
                     ret_in = ST_BFS;
                  end
               end
            end else if (col_lt) begin
               pha_in = 1'b1;
            end
         end
         ST_DELTA: begin
            if (col_lt) begin
               if (org_ok_ff[t] && !itt_ff[t]) begin
                  if (!found_ff || ms_ff[t] < delta_ff) delta_in = ms_ff[t];
                  found_in = 1'b1;
               end
               col_in = col_ff + cnt_type'(1);
            end else begin
               col_in = '0;
            end
         end
         ST_ADJUST: begin
            if (col_lt) begin
               if (org_ok_ff[t] && !itt_ff[t]) ms_in[t] = ms_ff[t] - delta_ff;
               if (its_ff[t]) sl_in[t] = sl_ff[t] - delta_ff[LABEL_BITS-1:0];
               if (itt_ff[t]) tl_in[t] = tl_ff[t] + delta_ff[LABEL_BITS-1:0];
               col_in = col_ff + cnt_type'(1);
            end else begin
               col_in = '0;
            end
         end
         ST_SCAN: begin
            if (col_lt) begin
               col_in = col_ff + cnt_type'(1);
               if (!sc_skip) begin
                  if (!pot_ok_ff[t]) begin
                     ptt_in[t] = org_ff[t];  ptt_ok_in[t] = 1'b1;
                     path_t_in = t;  path_ok_in = 1'b1;  col_in = '0;
                  end else if (!its_ff[m]) begin
                     grow_en = 1'b1;  g_s = org_ff[t];  g_t = t;  g_m = m;
                     ret_in = ST_SCAN;
                  end else begin
                     itt_in[t] = 1'b1;
                     ptt_in[t] = org_ff[t];  ptt_ok_in[t] = 1'b1;
                  end
               end
            end
         end
         ST_PATH: begin
            if (path_done) begin
               rnd_in = rnd_ff + cnt_type'(1);
               col_in = '0;
            end else begin
               pos_in[ptt_ff[path_t_ff]] = path_t_ff;
               pos_ok_in[ptt_ff[path_t_ff]] = 1'b1;
               pot_in[path_t_ff] = ptt_ff[path_t_ff];
               pot_ok_in[path_t_ff] = 1'b1;
               path_t_in = pts_ff[ptt_ff[path_t_ff]];
               path_ok_in = pts_ok_ff[ptt_ff[path_t_ff]];
               col_in = col_ff + cnt_type'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_src_in = t;
               rsp_tgt_in = pos_ok_ff[t] ? pos_ff[t] : '0;
               rsp_succ_in = 1'b1;
               rsp_last_in = (col_ff == n_last);
               col_in = col_ff + cnt_type'(1);
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_src_in = '0;  rsp_tgt_in = '0;
               rsp_succ_in = 1'b0;  rsp_last_in = 1'b1;
            end
         end
         default: ;
      endcase

      // tree growth: mark target and its partner, queue the partner, then walk its slacks
      if (grow_en) begin
         itt_in[g_t] = 1'b1;
         its_in[g_m] = 1'b1;
         pts_in[g_m] = g_t;  pts_ok_in[g_m] = 1'b1;
         ptt_in[g_t] = g_s;  ptt_ok_in[g_t] = 1'b1;
         if (qc_ff < cnt_type'(MAX_VERTICES)) begin
            q_in[qh_ff + qc_ff[VID_BITS-1:0]] = g_m;
            qc_in = qc_ff + cnt_type'(1);
         end
         slk_src_in = g_m;  slk_col_in = '0;  pha_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pha_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ev_ff <= '0;
         pos_ok_ff <= '0;
         pot_ok_ff <= '0;
      end else begin
         state_ff <= state_in;
         pha_ff <= pha_in;
         rsp_valid_ff <= rsp_valid_in;
         ev_ff <= ev_in;
         pos_ok_ff <= pos_ok_in;
         pot_ok_ff <= pot_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;  col_ff <= col_in;  slk_col_ff <= slk_col_in;
      rnd_ff <= rnd_in;  qc_ff <= qc_in;  cur_src_ff <= cur_src_in;
      slk_src_ff <= slk_src_in;  qh_ff <= qh_in;
      path_t_ff <= path_t_in;  path_ok_ff <= path_ok_in;
      best_ff <= best_in;  any_ff <= any_in;  found_ff <= found_in;  delta_ff <= delta_in;
      sl_ff <= sl_in;  tl_ff <= tl_in;  ms_ff <= ms_in;  org_ff <= org_in;
      pos_ff <= pos_in;  pot_ff <= pot_in;  ptt_ff <= ptt_in;  pts_ff <= pts_in;
      q_ff <= q_in;
      org_ok_ff <= org_ok_in;  ptt_ok_ff <= ptt_ok_in;  pts_ok_ff <= pts_ok_in;
      its_ff <= its_in;  itt_ff <= itt_in;
      rsp_src_ff <= rsp_src_in;  rsp_tgt_ff <= rsp_tgt_in;
      rsp_succ_ff <= rsp_succ_in;  rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

@@ sv/max_weight_perfect_matching.sv @@
// Top level of the max-weight perfect matching block (Hungarian method).
// Depends on mwpm_pkg, mwpm_if, mwpm_weight_ram and mwpm_engine.
//
//   channel   dir  handshake          beat
//   req_bus   in   valid/ready        edge load (mode 0) or run start (mode 1)
//   rsp_bus   out  valid/ready        one matched pair, or one failure beat
//   csr_*     in   csr_wr_en strobe   active vertex count n
//
// A run first walks the weight memory to set the source labels (all 16 rows
// are visited, only the active ones read their edges), then performs n
// augmentations. Each walk over a vertex's edges issues a read and then
// evaluates it for each target, set by the single registered read port of
// the weight memory; delta, label update and slack scan passes read no memory.
// After the run come n result beats (or one failure beat).
// Synchronous active-high reset clears the control state and edge valid bits.
// req_bus stays not ready for the whole run; rsp_bus stalls hold the result
// register and the sequencer.
`default_nettype none

module max_weight_perfect_matching import mwpm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mwpm_req_if.sink      req_bus,
   mwpm_rsp_if.source    rsp_bus,
   input  logic          csr_wr_en,
   input  logic [4:0]    csr_wr_data
);

   logic [4:0] active_ff;
   cnt_type    n_active;
   wr_req_type ram_wr;
   addr_type   ram_rd_addr;
   weight_type ram_rd_data;

   // hold the vertex count register; write takes effect on the strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 5'd16;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // clamp n into 1..MAX_VERTICES
   always_comb begin
      if (active_ff == '0) begin
         n_active = cnt_type'(1);
      end else if (32'(active_ff) > MAX_VERTICES) begin
         n_active = cnt_type'(MAX_VERTICES);
      end else begin
         n_active = cnt_type'(active_ff);
      end
   end

   mwpm_weight_ram u_ram (
      .clock   (clock),
      .wr_req  (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mwpm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .n_active    (n_active),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .ram_wr      (ram_wr),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb_mwpm_if.sv @@
// Testbench copy of nothing: the channel interfaces come from sv/mwpm_if.sv.
// This file holds the item types for stimulus and expected pairs; depends on mwpm_pkg.
`default_nettype none

package tb_mwpm_pkg;
   import mwpm_pkg::*;

   typedef struct {
      logic       mode;
      vid_type    source_index;
      vid_type    target_index;
      weight_type edge_weight;
      logic       edge_present;
      int         hold;      // idle cycles before offering the beat
      int         new_n;     // -1: no register write before this beat
   } req_item_type;

   typedef struct {
      vid_type matched_source;
      vid_type matched_target;
      logic    success;
      logic    last;
   } pair_type;
endpackage

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking bench for max_weight_perfect_matching: directed and random edge
// loads and matching runs, with a built-in Hungarian predictor. Depends on mwpm_pkg,
// mwpm_if, tb_mwpm_pkg and max_weight_perfect_matching.
`default_nettype none

module tb;
   import mwpm_pkg::*;
   import tb_mwpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = 5'd0;

   mwpm_req_if req_bus ();
   mwpm_rsp_if rsp_bus ();

   max_weight_perfect_matching uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the edge memory and the register.
   // ---------------------------------------------------------------------
   longint     w_mem [EDGE_SLOTS];
   bit         w_ok  [EDGE_SLOTS];
   logic [4:0] n_reg;
   pair_type   pending_pairs [$];
   req_item_type plan [$];
   int         errors;
   int         hold_off;      // receiver hold-off cycles left
   int         hold_mark = -1; // plan size at which the hold-off starts
   bit         hold_done;
   bit         stim_done;

   // Hungarian working state.
   longint lab_s [MAX_VERTICES], lab_t [MAX_VERTICES], slk [MAX_VERTICES];
   int     mate_s [MAX_VERTICES], mate_t [MAX_VERTICES], org [MAX_VERTICES];
   int     par_s [MAX_VERTICES], par_t [MAX_VERTICES], bfs [MAX_VERTICES];
   bit     tr_s [MAX_VERTICES], tr_t [MAX_VERTICES];
   int     q_hd, q_ct, nv;

   function automatic longint slack_of(int s, int t);
      return lab_s[s] + lab_t[t] - w_mem[s*MAX_VERTICES+t];
   endfunction

   function automatic void relax_from(int s);
      longint v;
      for (int t = 0; t < nv; t++)
         if (w_ok[s*MAX_VERTICES+t]) begin
            v = slack_of(s, t);
            if (org[t] < 0 || v < slk[t]) begin
               slk[t] = v;
               org[t] = s;
            end
         end
   endfunction

   function automatic void enqueue(int s);
      if (q_ct < MAX_VERTICES) begin
         bfs[(q_hd + q_ct) % MAX_VERTICES] = s;
         q_ct++;
      end
   endfunction

   function automatic void attach(int s, int t, int m);
      tr_t[t] = 1;
      tr_s[m] = 1;
      par_s[m] = t;
      par_t[t] = s;
      enqueue(m);
      relax_from(m);
   endfunction

   // One augmenting path from the lowest exposed source; 0 on failure.
   function automatic bit grow_path();
      int root, fin, s, t, nt, m;
      longint delta;
      bit found;
      root = -1;
      fin = -1;
      for (s = 0; s < nv; s++)
         if (mate_s[s] < 0) begin
            root = s;
            break;
         end
      if (root < 0) return 0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         tr_s[i] = 0; tr_t[i] = 0; par_s[i] = -1; par_t[i] = -1;
         org[i] = -1; slk[i] = 0;
      end
      q_hd = 0;
      q_ct = 0;
      tr_s[root] = 1;
      relax_from(root);
      enqueue(root);
      forever begin
         delta = 0;
         found = 0;
         while (fin < 0 && q_ct > 0) begin
            s = bfs[q_hd];
            q_hd = (q_hd + 1) % MAX_VERTICES;
            q_ct--;
            for (t = 0; t < nv; t++) begin
               if (!w_ok[s*MAX_VERTICES+t] || tr_t[t] || slack_of(s, t) != 0) continue;
               if (mate_t[t] < 0) begin
                  fin = t;
                  par_t[t] = s;
                  break;
               end
               attach(s, t, mate_t[t]);
            end
         end
         if (fin >= 0) break;
         for (t = 0; t < nv; t++)
            if (org[t] >= 0 && !tr_t[t]) begin
               if (!found || slk[t] < delta) delta = slk[t];
               found = 1;
            end
         if (!found || delta == 0) return 0;
         for (t = 0; t < nv; t++)
            if (org[t] >= 0 && !tr_t[t]) slk[t] -= delta;
         for (int i = 0; i < nv; i++) begin
            if (tr_s[i]) lab_s[i] -= delta;
            if (tr_t[i]) lab_t[i] += delta;
         end
         for (t = 0; t < nv && fin < 0; t++) begin
            if (tr_t[t] || org[t] < 0 || slk[t] != 0) continue;
            if (mate_t[t] < 0) begin
               fin = t;
               par_t[t] = org[t];
               break;
            end
            m = mate_t[t];
            if (!tr_s[m]) attach(org[t], t, m);
            else begin
               tr_t[t] = 1;
               par_t[t] = org[t];
            end
         end
         if (fin >= 0) break;
      end
      t = fin;
      for (int i = 0; i < nv && t >= 0 && t < nv; i++) begin
         s = par_t[t];
         if (s < 0 || s >= nv) break;
         nt = par_s[s];
         mate_s[s] = t;
         mate_t[t] = s;
         t = nt;
      end
      return 1;
   endfunction

   // Work out the beats of one run and queue them as expectations.
   function automatic void predict_matching();
      pair_type p;
      bit any;
      longint best;
      nv = (n_reg == 0) ? 1 : (n_reg > MAX_VERTICES) ? MAX_VERTICES : int'(n_reg);
      for (int s = 0; s < MAX_VERTICES; s++) begin
         any = 0;
         best = 0;
         mate_s[s] = -1;
         mate_t[s] = -1;
         lab_t[s] = 0;
         if (s < nv)
            for (int t = 0; t < nv; t++)
               if (w_ok[s*MAX_VERTICES+t] && (!any || w_mem[s*MAX_VERTICES+t] > best)) begin
                  best = w_mem[s*MAX_VERTICES+t];
                  any = 1;
               end
         lab_s[s] = best;
      end
      for (int k = 0; k < nv; k++)
         if (!grow_path()) begin
            p.matched_source = '0;
            p.matched_target = '0;
            p.success = 1'b0;
            p.last = 1'b1;
            pending_pairs = {pending_pairs, p};
            return;
         end
      for (int s = 0; s < nv; s++) begin
         p.matched_source = vid_type'(s);
         p.matched_target = vid_type'(mate_s[s] < 0 ? 0 : mate_s[s]);
         p.success = 1'b1;
         p.last = (s == nv - 1);
         pending_pairs = {pending_pairs, p};
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus planning helpers.
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   function automatic void add_edge(int s, int t, int w, bit pres, int new_n = -1);
      req_item_type it;
      it.mode = 1'b0;
      it.source_index = vid_type'(s);
      it.target_index = vid_type'(t);
      it.edge_weight = weight_type'(w);
      it.edge_present = pres;
      it.hold = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      it.new_n = new_n;
      plan = {plan, it};
   endfunction

   function automatic void add_start(int new_n = -1);
      req_item_type it;
      it.mode = 1'b1;
      it.source_index = vid_type'($urandom);
      it.target_index = vid_type'($urandom);
      it.edge_weight = weight_type'($urandom);
      it.edge_present = $urandom_range(0, 1);
      it.hold = pick_gap();
      it.new_n = new_n;
      plan = {plan, it};
   endfunction

   // Random square of size n: dense edges with random content, some holes.
   function automatic void add_random_graph(int n, int new_n);
      int wide;
      wide = $urandom_range(0, 2);
      for (int s = 0; s < n; s++)
         for (int t = 0; t < n; t++)
            add_edge(s, t,
                     wide == 0 ? int'($urandom_range(0, 65535)) - 32768
                               : int'($urandom_range(0, 20)) - 10,
                     $urandom_range(0, 15) != 0,
                     (s == 0 && t == 0) ? new_n : -1);
      // noise edge, outside the active square unless n is the full size
      add_edge($urandom_range(n, 15), $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
      add_start();
   endfunction

   // ---------------------------------------------------------------------
   // Driver: the planned items one by one; register writes only when idle.
   // ---------------------------------------------------------------------
   int  gap_left;
   bit  cur_loaded;
   req_item_type cur;
   int  settle;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = 1'b0;
      req_bus.source_index = '0;
      req_bus.target_index = '0;
      req_bus.edge_weight = '0;
      req_bus.edge_present = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      bit wr_now;
      wr_now = 1'b0;
      if (reset) begin
         gap_left <= 0;
         cur_loaded <= 1'b0;
         settle <= 0;
      end else if (req_bus.valid && req_bus.ready) begin
         // beat taken: update the predictor, then advance
         if (cur.mode) predict_matching();
         else begin
            w_mem[{cur.source_index, cur.target_index}] = cur.edge_weight;
            w_ok[{cur.source_index, cur.target_index}] = cur.edge_present;
         end
         req_bus.valid <= 1'b0;
         cur_loaded <= 1'b0;
      end else if (!cur_loaded) begin
         if (plan.size() > 0) begin
            cur = plan.pop_front();
            cur_loaded <= 1'b1;
            gap_left <= cur.hold;
            settle <= 0;
         end else
            stim_done <= 1'b1;
      end else if (!req_bus.valid) begin
         if (cur.new_n >= 0 && (pending_pairs.size() > 0 || settle < 40)) begin
            // drain and let the block settle before touching the register
            if (pending_pairs.size() == 0) settle <= settle + 1;
         end else if (cur.new_n >= 0) begin
            wr_now = 1'b1;
            csr_wr_data <= 5'(cur.new_n);
            n_reg = 5'(cur.new_n);
            cur.new_n = -1;
         end else if (gap_left > 0)
            gap_left <= gap_left - 1;
         else begin
            req_bus.valid <= 1'b1;
            req_bus.mode <= cur.mode;
            req_bus.source_index <= cur.source_index;
            req_bus.target_index <= cur.target_index;
            req_bus.edge_weight <= cur.edge_weight;
            req_bus.edge_present <= cur.edge_present;
         end
      end
      csr_wr_en <= wr_now;
   end

   // ---------------------------------------------------------------------
   // Receiver hold-off: one long stretch once the plan reaches the mark.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 0;
         hold_done <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end else if (!hold_done && hold_mark >= 0 && plan.size() <= hold_mark) begin
         hold_off <= 1000;
         hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random ready with one long hold-off, then check.
   // ---------------------------------------------------------------------
   int stall_left;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      pair_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pairs.size() == 0)
               report_mismatch("unexpected beat, source", rsp_bus.matched_source, -1);
            else begin
               want = pending_pairs.pop_front();
               if (rsp_bus.matched_source !== want.matched_source)
                  report_mismatch("matched_source", rsp_bus.matched_source, want.matched_source);
               if (rsp_bus.matched_target !== want.matched_target)
                  report_mismatch("matched_target", rsp_bus.matched_target, want.matched_target);
               if (rsp_bus.success !== want.success)
                  report_mismatch("success", rsp_bus.success, want.success);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", rsp_bus.last, want.last);
            end
         end
         // hold ready low during the long hold-off, else random stalls
         if (hold_off > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left <= pick_gap();
         end else
            rsp_bus.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Plan: directed graphs first, then random graphs of mixed sizes.
   // ---------------------------------------------------------------------
   initial begin
      int sz;
      int mark;
      errors = 0;
      stim_done = 0;
      n_reg = 5'd16;
      for (int i = 0; i < EDGE_SLOTS; i++) begin
         w_mem[i] = 0;
         w_ok[i] = 0;
      end
      // extreme weights on a 2x2 square, all edges present
      add_edge(0, 0, 32767, 1, 2);
      add_edge(0, 1, -32768, 1);
      add_edge(1, 0, -32768, 1);
      add_edge(1, 1, 32767, 1);
      add_edge(15, 15, -1, 0);     // outside the active square
      add_start();
      add_edge(0, 0, 5, 1);        // forces a label change
      add_edge(0, 1, 5, 1);
      add_edge(1, 0, 5, 1);
      add_edge(1, 1, -32768, 0);   // removed edge
      add_start();
      add_edge(1, 0, 0, 0);        // source 1 left without edges: failure
      add_start();
      add_start(0);                // zero count acts as one
      add_start(31);               // above range acts as the full size
      add_edge(0, 0, 1, 1, 1);     // single vertex
      add_start();
      add_edge(0, 0, 0, 0, 16);    // clear edge, full size fails quickly
      add_start();
      for (int g = 0; g < 4; g++) begin
         sz = $urandom_range(2, 4);
         add_random_graph(sz, sz);
      end
      // long receiver hold-off while the sender keeps offering
      mark = plan.size();
      for (int g = 0; g < 3; g++) begin
         add_random_graph($urandom_range(1, 4), -1);
         plan[plan.size()-1].hold = 0;
      end
      add_random_graph(16, 16);
      add_random_graph($urandom_range(1, 5), $urandom_range(1, 5));
      hold_mark = plan.size() - mark;
   end

   // Reset, then wait for the end of stimulus and the last expected beat.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      // sender pause until all beats are back, then trailing latency
      while (pending_pairs.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_pairs.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb NOT OK");
      $finish;
   end
endmodule

`default_nettype wire

@@ files.f @@
sv/mwpm_pkg.sv
sv/mwpm_if.sv
sv/mwpm_weight_ram.sv
sv/mwpm_engine.sv
sv/max_weight_perfect_matching.sv
tb/sv/tb_mwpm_if.sv
tb/sv/tb.sv
